FILE: hdl/dqr_pkg.sv
package dqr_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [VALUE_WIDTH-1:0] word_t;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROT_LEFT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROT_RIGHT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_ROT_LEFT,
        OP_ROT_RIGHT,
        OP_DELETE,
        OP_READ,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_ROTATE,
        BK_SHIFT
    } back_state_t;

    typedef struct packed {
        op_t              op;
        word_t            value;
        logic [POS_W-1:0] position;
    } cmd_entry_t;

    function automatic op_t decode_op(logic [CMD_W-1:0] cmd);
        op_t op;
        case (cmd)
            CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  op = OP_PUSH_BACK;
            CMD_ROT_LEFT:   op = OP_ROT_LEFT;
            CMD_ROT_RIGHT:  op = OP_ROT_RIGHT;
            CMD_DELETE:     op = OP_DELETE;
            CMD_READ:       op = OP_READ;
            default:        op = OP_NONE;
        endcase
        return op;
    endfunction

    // sign-extend the 32-bit field, keep the low store bits
    function automatic word_t to_store(logic signed [DATA_W-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    // sign-extend a stored word, cut to the 32-bit field
    function automatic logic [DATA_W-1:0] from_store(word_t s);
        logic signed [63:0] wide;
        wide = 64'(signed'(s));
        return wide[DATA_W-1:0];
    endfunction

    // ring index base + off, off never above DEPTH
    function automatic ptr_t wrap_add(ptr_t base, cnt_t off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic ptr_t ptr_dec(ptr_t p);
        ptr_t r;
        if (p == '0)
        begin
            r = PTR_W'(DEPTH - 1);
        end
        else
        begin
            r = p - 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/dqr_ram.sv
module dqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/dqr_front.sv
module dqr_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [dqr_pkg::CMD_W-1:0]              cmd,
    input  logic signed [dqr_pkg::DATA_W-1:0]      value,
    input  logic [dqr_pkg::POS_W-1:0]              position,
    output logic                                   cq_valid,
    output dqr_pkg::cmd_entry_t                    cq_entry,
    input  logic                                   cq_take
);

    import dqr_pkg::*;

    cmd_entry_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                wr_en;
    logic                rd_en;
    cmd_entry_t          new_entry;

    // classify the incoming transaction
    always_comb
    begin
        new_entry.op       = decode_op(cmd);
        new_entry.value    = to_store(value);
        new_entry.position = position;
    end

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign wr_en    = push && !full;
    assign cq_valid = (cnt_reg != '0);
    assign rd_en    = cq_take && cq_valid;
    assign cq_entry = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

FILE: hdl/dqr_back.sv
module dqr_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cq_valid,
    input  dqr_pkg::cmd_entry_t                    cq_entry,
    output logic                                   cq_take,
    output logic                                   ram_we,
    output dqr_pkg::ptr_t                          ram_waddr,
    output dqr_pkg::word_t                         ram_wdata,
    output logic                                   ram_re,
    output dqr_pkg::ptr_t                          ram_raddr,
    input  dqr_pkg::word_t                         ram_rdata,
    output logic                                   res_valid,
    input  logic                                   res_pop,
    output logic [dqr_pkg::STAT_W-1:0]             res_status,
    output logic [dqr_pkg::DATA_W-1:0]             res_data,
    output logic [dqr_pkg::FILL_W-1:0]             res_count
);

    import dqr_pkg::*;

    back_state_t         state_reg, state_next;
    ptr_t                fp_reg, fp_next;
    cnt_t                count_reg, count_next;
    cnt_t                idx_reg, idx_next;
    ptr_t                wa_reg, wa_next;
    logic                res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [FILL_W-1:0]   res_count_reg, res_count_next;
    logic                res_free;
    logic                res_load;
    logic                pos_ok;
    cnt_t                pos_idx;

    assign res_free = !res_valid_reg || res_pop;
    assign pos_ok   = (cq_entry.position != '0) &&
                      (cq_entry.position <= POS_W'(count_reg));
    assign pos_idx  = CNT_W'(cq_entry.position - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        fp_next         = fp_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wa_next         = wa_reg;
        cq_take         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wa_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = fp_reg;
        res_load        = 1'b0;
        res_status_next = ST_DONE;
        res_data_next   = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cq_valid && res_free)
                begin
                    cq_take = 1'b1;
                    case (cq_entry.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = cq_entry.value;
                                count_next = count_reg + 1'b1;
                                if (cq_entry.op == OP_PUSH_FRONT)
                                begin
                                    ram_waddr = ptr_dec(fp_reg);
                                    fp_next   = ptr_dec(fp_reg);
                                end
                                else
                                begin
                                    ram_waddr = wrap_add(fp_reg, count_reg);
                                end
                            end
                        end
                        OP_ROT_LEFT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                // front element goes behind the back one
                                ram_re     = 1'b1;
                                ram_raddr  = fp_reg;
                                wa_next    = wrap_add(fp_reg, count_reg);
                                fp_next    = wrap_add(fp_reg, CNT_W'(1));
                                state_next = BK_ROTATE;
                            end
                        end
                        OP_ROT_RIGHT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = wrap_add(fp_reg, count_reg - 1'b1);
                                wa_next    = ptr_dec(fp_reg);
                                fp_next    = ptr_dec(fp_reg);
                                state_next = BK_ROTATE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                res_load        = 1'b1;
                                res_status_next = ST_RANGE;
                            end
                            else if (pos_idx + 1'b1 < count_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = wrap_add(fp_reg, pos_idx + 1'b1);
                                idx_next   = pos_idx;
                                state_next = BK_SHIFT;
                            end
                            else
                            begin
                                // last element: nothing to close up
                                count_next = count_reg - 1'b1;
                                res_load   = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (!pos_ok)
                            begin
                                res_load        = 1'b1;
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = wrap_add(fp_reg, pos_idx);
                                state_next = BK_READ;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                res_load      = 1'b1;
                res_data_next = from_store(ram_rdata);
                state_next    = BK_IDLE;
            end
            BK_ROTATE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wa_reg;
                res_load   = 1'b1;
                state_next = BK_IDLE;
            end
            BK_SHIFT:
            begin
                // move element idx+1 down to idx, fetch the next one
                ram_we    = 1'b1;
                ram_waddr = wrap_add(fp_reg, idx_reg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg + CNT_W'(2) < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = wrap_add(fp_reg, idx_reg + CNT_W'(2));
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_count_next = FILL_W'(count_next);
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fp_reg        <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fp_reg        <= fp_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        wa_reg  <= wa_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_count_reg  <= res_count_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_data   = res_data_reg;
    assign res_count  = res_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fp_reg < PTR_W'(DEPTH - 1) || fp_reg == PTR_W'(DEPTH - 1))
        else $error("front pointer outside the ring");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |-> !res_valid_reg)
        else $error("command in flight while a result waits");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_pop |=> res_valid_reg && $stable(res_count_reg)
            && $stable(res_status_reg))
        else $error("waiting result changed before pop");

endmodule

FILE: hdl/deque_with_rotation.sv
// channel   | handshake        | fields
// ----------+------------------+-----------------------------------------
// command   | push / full      | cmd[2:0], value[31:0] signed, position[6:0]
// result    | pop / empty      | status[1:0], data[31:0] signed, fill_count[6:0]
//
// commands pass through the command queue, then the back end: push writes the store
// directly, rotate and read read the store first, delete closes up the gap, one element
// moved per cycle through the single write port of the ring store
// reset: rst_n asynchronous, clears pointers, counts and valid flags; store
// contents stay undefined until written, no clearing pass
// stalls: two-entry command queue in front, one result register at the back
module deque_with_rotation (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [dqr_pkg::CMD_W-1:0]              cmd,
    input  logic signed [dqr_pkg::DATA_W-1:0]      value,
    input  logic [dqr_pkg::POS_W-1:0]              position,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [dqr_pkg::STAT_W-1:0]             status,
    output logic signed [dqr_pkg::DATA_W-1:0]      data,
    output logic [dqr_pkg::FILL_W-1:0]             fill_count
);

    import dqr_pkg::*;

    // decoded command transactions from front to back
    logic         cq_valid;
    cmd_entry_t   cq_entry;
    logic         cq_take;

    // ring store port
    logic         ram_we;
    ptr_t         ram_waddr;
    word_t        ram_wdata;
    logic         ram_re;
    ptr_t         ram_raddr;
    word_t        ram_rdata;

    // result register
    logic                res_valid;
    logic                res_pop;
    logic [STAT_W-1:0]   res_status;
    logic [DATA_W-1:0]   res_data;
    logic [FILL_W-1:0]   res_count;

    // front: accept and classify commands into a short queue
    dqr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .value    (value),
        .position (position),
        .cq_valid (cq_valid),
        .cq_entry (cq_entry),
        .cq_take  (cq_take)
    );

    // back: pointer and count bookkeeping, store accesses, result register
    dqr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cq_valid   (cq_valid),
        .cq_entry   (cq_entry),
        .cq_take    (cq_take),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_pop    (res_pop),
        .res_status (res_status),
        .res_data   (res_data),
        .res_count  (res_count)
    );

    // ring store, one write and one registered read per cycle
    dqr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result side looks like the read end of a queue
    assign empty      = !res_valid;
    assign res_pop    = pop && res_valid;
    assign status     = res_status;
    assign data       = res_data;
    assign fill_count = res_count;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import dqr_pkg::*;

    // codes the block must ignore, not named in the package
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int PHASE_ITEMS  = 535;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    // one result transaction as it leaves the block
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [FILL_W-1:0] fill;
    } result_t;

    // one row of the directed table, want is used only when typed is set
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic              typed;
        result_t           want;
    } dir_row_t;

    // random command mix, chosen per segment to drive the fill level around
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // empty queue: out of range reads and deletes, rotations do nothing
        '{CMD_READ,       32'h0000_0000, 7'd1,   1'b1, '{ST_RANGE, 32'h0000_0000, 7'd0}},
        '{CMD_DELETE,     32'h0000_0000, 7'd0,   1'b1, '{ST_RANGE, 32'h0000_0000, 7'd0}},
        '{CMD_ROT_LEFT,   32'h0000_0000, 7'd0,   1'b1, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_ROT_RIGHT,  32'h0000_0000, 7'd0,   1'b1, '{ST_DONE,  32'h0000_0000, 7'd0}},
        // spare codes are ignored
        '{CMD_SPARE_6,    32'hFFFF_FFFF, 7'd127, 1'b1, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_SPARE_7,    32'h8000_0000, 7'd64,  1'b1, '{ST_DONE,  32'h0000_0000, 7'd0}},
        // value extremes at both ends
        '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 7'd127, 1'b1, '{ST_DONE,  32'h0000_0000, 7'd1}},
        '{CMD_PUSH_FRONT, 32'h8000_0000, 7'd0,   1'b1, '{ST_DONE,  32'h0000_0000, 7'd2}},
        '{CMD_READ,       32'hFFFF_FFFF, 7'd1,   1'b1, '{ST_DONE,  32'h8000_0000, 7'd2}},
        '{CMD_READ,       32'h0000_0000, 7'd2,   1'b1, '{ST_DONE,  32'h7FFF_FFFF, 7'd2}},
        // one past the back, position zero and the top position
        '{CMD_READ,       32'h0000_0000, 7'd3,   1'b1, '{ST_RANGE, 32'h0000_0000, 7'd2}},
        '{CMD_READ,       32'h0000_0000, 7'd0,   1'b1, '{ST_RANGE, 32'h0000_0000, 7'd2}},
        '{CMD_READ,       32'h0000_0000, 7'd127, 1'b1, '{ST_RANGE, 32'h0000_0000, 7'd2}},
        '{CMD_DELETE,     32'h0000_0000, 7'd127, 1'b1, '{ST_RANGE, 32'h0000_0000, 7'd2}},
        // the rest goes through the predictor
        '{CMD_PUSH_BACK,  32'h0000_0000, 7'd5,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_ROT_LEFT,   32'h0000_0000, 7'd0,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_READ,       32'h0000_0000, 7'd1,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_ROT_RIGHT,  32'h0000_0000, 7'd0,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 7'd0,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_DELETE,     32'h0000_0000, 7'd2,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_READ,       32'h0000_0000, 7'd3,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_DELETE,     32'h0000_0000, 7'd1,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_DELETE,     32'h0000_0000, 7'd2,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}},
        '{CMD_READ,       32'h0000_0000, 7'd1,   1'b0, '{ST_DONE,  32'h0000_0000, 7'd0}}
    };

    // cumulative thresholds out of 100: push, rotate, read, delete, rest is noise
    int push_top [3] = '{70, 15, 35};
    int rot_top  [3] = '{78, 25, 50};
    int read_top [3] = '{86, 40, 68};
    int del_top  [3] = '{94, 90, 88};

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [FILL_W-1:0]        fill_count;

    // predictor state: ring contents, front index and fill level
    word_t dq_ring [DEPTH];
    int    dq_front;
    int    dq_held;

    result_t pending_results [$];

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_request = 1'b0;
    logic hold_off     = 1'b0;
    int   mismatches   = 0;
    int   cycle_count  = 0;

    deque_with_rotation DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .data       (data),
        .fill_count (fill_count)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("result mismatch at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    // pushed value: sign-extend the 32-bit field, keep the store width
    function automatic word_t to_ring(logic [DATA_W-1:0] v);
        logic [63:0] w;
        w = {{32{v[DATA_W-1]}}, v};
        return w[VALUE_WIDTH-1:0];
    endfunction

    // read value: sign-extend the stored word, cut to the data field
    function automatic logic [DATA_W-1:0] from_ring(word_t s);
        logic [63:0] w;
        w = {64{s[VALUE_WIDTH-1]}};
        w[VALUE_WIDTH-1:0] = s;
        return w[DATA_W-1:0];
    endfunction

    // predicts one command and advances the predictor state
    function automatic result_t predict_command(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v,
                                                logic [POS_W-1:0] p);
        result_t r;
        int      pos;
        int      i;
        r.status = ST_DONE;
        r.data   = '0;
        pos      = int'(p);
        case (c)
            CMD_PUSH_FRONT:
            begin
                if (dq_held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    dq_front = (dq_front + DEPTH - 1) % DEPTH;
                    dq_ring[dq_front] = to_ring(v);
                    dq_held++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (dq_held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    dq_ring[(dq_front + dq_held) % DEPTH] = to_ring(v);
                    dq_held++;
                end
            end
            CMD_ROT_LEFT:
            begin
                // when full the copy lands on itself and only the front moves
                if (dq_held != 0)
                begin
                    dq_ring[(dq_front + dq_held) % DEPTH] = dq_ring[dq_front];
                    dq_front = (dq_front + 1) % DEPTH;
                end
            end
            CMD_ROT_RIGHT:
            begin
                if (dq_held != 0)
                begin
                    dq_front = (dq_front + DEPTH - 1) % DEPTH;
                    dq_ring[dq_front] = dq_ring[(dq_front + dq_held) % DEPTH];
                end
            end
            CMD_DELETE:
            begin
                if (pos < 1 || pos > dq_held)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    // close the gap toward the front
                    for (i = pos - 1; i + 1 < dq_held; i++)
                    begin
                        dq_ring[(dq_front + i) % DEPTH] = dq_ring[(dq_front + i + 1) % DEPTH];
                    end
                    dq_held--;
                end
            end
            CMD_READ:
            begin
                if (pos < 1 || pos > dq_held)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.data = from_ring(dq_ring[(dq_front + pos - 1) % DEPTH]);
                end
            end
            default:
            begin
                // spare codes leave everything as it is
            end
        endcase
        r.fill = FILL_W'(dq_held);
        return r;
    endfunction

    // offers one command transaction, waits for it to be taken, records the expectation
    task automatic offer_command(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
                                 input logic [POS_W-1:0] p, input logic typed,
                                 input result_t typed_want);
        int      gap;
        result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        // push only drops when the sender actually idles
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        cmd      <= c;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        // accepted at this edge, predictor now reflects every accepted transaction
        predicted = predict_command(c, v, p);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // receiver: checks each accepted result transaction, then picks pop for the next edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result status=%0d data=%h fill=%0d",
                                        status, data, fill_count));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || data !== want.data || fill_count !== want.fill)
                begin
                    flag_mismatch($sformatf(
                        "expected status=%0d data=%h fill=%0d, got status=%0d data=%h fill=%0d",
                        want.status, want.data, want.fill, status, data, fill_count));
                end
            end
        end
        if (!rst_n || hold_off)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off so the result side backs up and full rises
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // stimulus
    initial
    begin
        int               row;
        int               phase;
        int               counted;
        int               seg_left;
        int               roll;
        mix_t             mode;
        logic [CMD_W-1:0] c;
        logic [DATA_W-1:0] v;
        logic [POS_W-1:0] p;

        rst_n         = 1'b0;
        push          = 1'b0;
        cmd           = '0;
        value         = '0;
        position      = '0;
        send_idle_pct = 36;
        recv_idle_pct = 61;
        dq_front      = 0;
        dq_held       = 0;
        seg_left      = 0;
        mode          = MIX_EVEN;
        for (row = 0; row < DEPTH; row++)
        begin
            dq_ring[row] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (row = 0; row < DIR_ROWS; row++)
        begin
            offer_command(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].value,
                          DIRECTED_ROWS[row].position, DIRECTED_ROWS[row].typed,
                          DIRECTED_ROWS[row].want);
        end

        // random part in three idling phases
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 61;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // sender keeps offering at full rate against a stalled receiver
                    hold_request = 1'b1;
                end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // segments of one mix walk the fill level between empty and full
                if (seg_left == 0)
                begin
                    mode     = mix_t'($urandom_range(2));
                    seg_left = $urandom_range(40, 200);
                end
                seg_left--;

                v = $urandom;
                if ($urandom_range(7) == 0)
                begin
                    case ($urandom_range(3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7FFF_FFFF;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
                // in-range position when there is anything to hit
                if (dq_held > 0)
                begin
                    p = POS_W'($urandom_range(1, dq_held));
                end
                else
                begin
                    p = POS_W'($urandom_range(127));
                end

                roll = $urandom_range(99);
                if (roll < push_top[int'(mode)])
                begin
                    c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                    p = POS_W'($urandom_range(127));
                end
                else if (roll < rot_top[int'(mode)])
                begin
                    c = $urandom_range(1) ? CMD_ROT_LEFT : CMD_ROT_RIGHT;
                end
                else if (roll < read_top[int'(mode)])
                begin
                    c = CMD_READ;
                end
                else if (roll < del_top[int'(mode)])
                begin
                    c = CMD_DELETE;
                end
                else
                begin
                    // noise: spare codes or any position at all
                    case ($urandom_range(3))
                        0:       c = CMD_SPARE_6;
                        1:       c = CMD_SPARE_7;
                        2:       c = CMD_READ;
                        default: c = CMD_DELETE;
                    endcase
                    p = POS_W'($urandom_range(127));
                end

                offer_command(c, v, p, 1'b0, '0);
                if (c != CMD_SPARE_6 && c != CMD_SPARE_7)
                begin
                    counted++;
                end
            end
        end

        // drain: every expectation met, then let any late extra result show up
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/dqr_pkg.sv
hdl/dqr_ram.sv
hdl/dqr_front.sv
hdl/dqr_back.sv
hdl/deque_with_rotation.sv
dv/testbench.sv
